[hw/rtl/gpg5x7_pkg.sv]
// ----------------------------------------------------------------------------
// gpg5x7_pkg: types and constants of the 5x7 glyph pixel generator
// Beat structs, the 5x7 font, register indexes and the sequencer program.
// ----------------------------------------------------------------------------
package gpg5x7_pkg;

	// Beat payloads
	typedef struct packed {
		logic [7:0]  char_code;
		logic [8:0]  pos_x;
		logic [8:0]  pos_y;
		logic [15:0] pen_color;
	} in_item_t;

	typedef struct packed {
		logic [16:0] pixel_address;
		logic [15:0] pixel_color;
		logic        last_pixel;
	} out_item_t;

	// Configuration register indexes
	localparam int          CFG_IDX_W      = 1;
	localparam int          CFG_DATA_W     = 8;
	localparam logic [0:0]  REG_TOP_ROW    = 1'd0;
	localparam logic [0:0]  REG_BOTTOM_ROW = 1'd1;
	localparam logic [7:0]  TOP_ROW_RST    = 8'd0;
	localparam logic [7:0]  BOTTOM_ROW_RST = 8'd240;

	// Glyph geometry: column 0..4, bit 0 of a column is the top row
	localparam int          GLYPH_COLS = 5;
	localparam int          GLYPH_ROWS = 7;
	localparam int          COL_W      = 3;
	localparam int          ROW_W      = 3;
	localparam logic [2:0]  LAST_COL   = 3'd4;
	localparam logic [2:0]  LAST_ROW   = 3'd6;
	localparam int          COORD_W    = 10;  // 9-bit position plus glyph offset
	localparam int          ADDR_W     = 17;

	typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

	localparam glyph_t FONT_UPPER [0:25] = '{
		'{7'd126, 7'd17,  7'd17,  7'd17,  7'd126},
		'{7'd127, 7'd73,  7'd73,  7'd73,  7'd54},
		'{7'd62,  7'd65,  7'd65,  7'd65,  7'd34},
		'{7'd127, 7'd65,  7'd65,  7'd34,  7'd28},
		'{7'd127, 7'd73,  7'd73,  7'd73,  7'd65},
		'{7'd127, 7'd9,   7'd9,   7'd9,   7'd1},
		'{7'd62,  7'd65,  7'd73,  7'd73,  7'd122},
		'{7'd127, 7'd8,   7'd8,   7'd8,   7'd127},
		'{7'd0,   7'd65,  7'd127, 7'd65,  7'd0},
		'{7'd32,  7'd64,  7'd65,  7'd63,  7'd1},
		'{7'd127, 7'd8,   7'd20,  7'd34,  7'd65},
		'{7'd127, 7'd64,  7'd64,  7'd64,  7'd64},
		'{7'd127, 7'd2,   7'd12,  7'd2,   7'd127},
		'{7'd127, 7'd4,   7'd8,   7'd16,  7'd127},
		'{7'd62,  7'd65,  7'd65,  7'd65,  7'd62},
		'{7'd127, 7'd9,   7'd9,   7'd9,   7'd6},
		'{7'd62,  7'd65,  7'd81,  7'd33,  7'd94},
		'{7'd127, 7'd9,   7'd25,  7'd41,  7'd70},
		'{7'd38,  7'd73,  7'd73,  7'd73,  7'd50},
		'{7'd1,   7'd1,   7'd127, 7'd1,   7'd1},
		'{7'd63,  7'd64,  7'd64,  7'd64,  7'd63},
		'{7'd31,  7'd32,  7'd64,  7'd32,  7'd31},
		'{7'd63,  7'd64,  7'd56,  7'd64,  7'd63},
		'{7'd99,  7'd20,  7'd8,   7'd20,  7'd99},
		'{7'd7,   7'd8,   7'd112, 7'd8,   7'd7},
		'{7'd97,  7'd81,  7'd73,  7'd69,  7'd67}
	};

	localparam glyph_t FONT_LOWER [0:25] = '{
		'{7'd32,  7'd84,  7'd84,  7'd84,  7'd120},
		'{7'd127, 7'd72,  7'd68,  7'd68,  7'd56},
		'{7'd56,  7'd68,  7'd68,  7'd68,  7'd32},
		'{7'd56,  7'd68,  7'd68,  7'd72,  7'd127},
		'{7'd56,  7'd84,  7'd84,  7'd84,  7'd24},
		'{7'd8,   7'd126, 7'd9,   7'd1,   7'd2},
		'{7'd12,  7'd82,  7'd82,  7'd82,  7'd62},
		'{7'd127, 7'd8,   7'd4,   7'd4,   7'd120},
		'{7'd0,   7'd68,  7'd125, 7'd64,  7'd0},
		'{7'd32,  7'd64,  7'd68,  7'd61,  7'd0},
		'{7'd127, 7'd16,  7'd40,  7'd68,  7'd0},
		'{7'd0,   7'd65,  7'd127, 7'd64,  7'd0},
		'{7'd124, 7'd4,   7'd24,  7'd4,   7'd120},
		'{7'd124, 7'd8,   7'd4,   7'd4,   7'd120},
		'{7'd56,  7'd68,  7'd68,  7'd68,  7'd56},
		'{7'd124, 7'd20,  7'd20,  7'd20,  7'd8},
		'{7'd8,   7'd20,  7'd20,  7'd24,  7'd124},
		'{7'd124, 7'd8,   7'd4,   7'd4,   7'd8},
		'{7'd72,  7'd84,  7'd84,  7'd84,  7'd32},
		'{7'd4,   7'd63,  7'd68,  7'd64,  7'd32},
		'{7'd60,  7'd64,  7'd64,  7'd32,  7'd124},
		'{7'd28,  7'd32,  7'd64,  7'd32,  7'd28},
		'{7'd60,  7'd64,  7'd48,  7'd64,  7'd60},
		'{7'd68,  7'd40,  7'd16,  7'd40,  7'd68},
		'{7'd12,  7'd80,  7'd80,  7'd80,  7'd60},
		'{7'd68,  7'd100, 7'd84,  7'd76,  7'd68}
	};

	localparam glyph_t FONT_DIGIT [0:9] = '{
		'{7'd62,  7'd81,  7'd73,  7'd69,  7'd62},
		'{7'd0,   7'd66,  7'd127, 7'd64,  7'd0},
		'{7'd98,  7'd81,  7'd73,  7'd73,  7'd70},
		'{7'd34,  7'd65,  7'd73,  7'd73,  7'd54},
		'{7'd24,  7'd20,  7'd18,  7'd127, 7'd16},
		'{7'd39,  7'd69,  7'd69,  7'd69,  7'd57},
		'{7'd60,  7'd74,  7'd73,  7'd73,  7'd48},
		'{7'd1,   7'd113, 7'd9,   7'd5,   7'd3},
		'{7'd54,  7'd73,  7'd73,  7'd73,  7'd54},
		'{7'd6,   7'd73,  7'd73,  7'd41,  7'd30}
	};

	// Character code to glyph bitmap; codes outside the font are blank
	function automatic glyph_t font_lookup(input logic [7:0] code);
		glyph_t     g;
		logic [7:0] ofs;
		g   = '0;
		ofs = '0;
		if (code >= "A" && code <= "Z") begin
			ofs = code - "A";
			g   = FONT_UPPER[ofs[4:0]];
		end else if (code >= "a" && code <= "z") begin
			ofs = code - "a";
			g   = FONT_LOWER[ofs[4:0]];
		end else if (code >= "0" && code <= "9") begin
			ofs = code - "0";
			g   = FONT_DIGIT[ofs[3:0]];
		end else begin
			unique case (code)
				":":     g = '{7'd0,  7'd36, 7'd36, 7'd0,   7'd0};
				".":     g = '{7'd0,  7'd0,  7'd64, 7'd0,   7'd0};
				",":     g = '{7'd0,  7'd0,  7'd96, 7'd0,   7'd0};
				"-":     g = '{7'd8,  7'd8,  7'd8,  7'd8,   7'd8};
				"_":     g = '{7'd64, 7'd64, 7'd64, 7'd64,  7'd64};
				"~":     g = '{7'd8,  7'd4,  7'd8,  7'd16,  7'd8};
				"/":     g = '{7'd32, 7'd16, 7'd8,  7'd4,   7'd2};
				"+":     g = '{7'd8,  7'd8,  7'd62, 7'd8,   7'd8};
				"=":     g = '{7'd20, 7'd20, 7'd20, 7'd20,  7'd20};
				"%":     g = '{7'd99, 7'd19, 7'd8,  7'd100, 7'd99};
				"(":     g = '{7'd0,  7'd0,  7'd62, 7'd65,  7'd0};
				")":     g = '{7'd0,  7'd65, 7'd62, 7'd0,   7'd0};
				">":     g = '{7'd0,  7'd65, 7'd34, 7'd28,  7'd0};
				"<":     g = '{7'd0,  7'd28, 7'd34, 7'd65,  7'd0};
				"?":     g = '{7'd2,  7'd1,  7'd81, 7'd9,   7'd6};
				default: g = '0;
			endcase
		end
		return g;
	endfunction

	// Sequencer microcode
	localparam int STEP_W     = 1;
	localparam int PROG_DEPTH = 2;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE = 1'd0;
	localparam step_t STEP_SCAN = 1'd1;

	typedef enum logic [1:0] {
		JMP_NEVER      = 2'd0,
		JMP_NO_START   = 2'd1,  // jump while no character is offered
		JMP_MORE_CELLS = 2'd2   // jump while glyph cells remain
	} jmp_cond_t;

	typedef struct packed {
		logic      busy;    // step holds a character
		logic      scan;    // test one glyph cell
		logic      flush;   // drain the held write as the final one
		jmp_cond_t cond;
		step_t     target;  // taken jump target; otherwise next step (wraps)
	} ctl_t;

	localparam ctl_t PROGRAM [PROG_DEPTH] = '{
		'{busy: 1'b0, scan: 1'b0, flush: 1'b1, cond: JMP_NO_START,   target: STEP_IDLE},
		'{busy: 1'b1, scan: 1'b1, flush: 1'b0, cond: JMP_MORE_CELLS, target: STEP_SCAN}
	};

endpackage

[hw/rtl/glyph_pixel_generator_5x7.sv]
// ----------------------------------------------------------------------------
// glyph_pixel_generator_5x7: 5x7 bitmap character to framebuffer writes
// Latency: a write is held until the next surviving cell is scanned and is on
//   the ports in the cycle after that scan; the final write of a character is
//   flushed in the idle step that follows the last scan and is then registered.
// Throughput: 35 cell scans plus one idle step per character; start is taken
//   only while idle. At most one write per cycle. The results cannot be stalled.
// Reset: clip rows go to 0 and 240, the sequencer to idle, no write pending.
// ----------------------------------------------------------------------------
module glyph_pixel_generator_5x7
	import gpg5x7_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              command,
	// configuration write port
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel writes
	output logic                  result_valid,
	output out_item_t             result
);

	// Screen bounds as 11-bit values (up to 2047) and the address product width
	localparam int         BOUND_W  = 11;
	localparam logic [BOUND_W-1:0] WIDTH_L  = BOUND_W'(SCREEN_WIDTH);
	localparam logic [BOUND_W-1:0] HEIGHT_L = BOUND_W'(SCREEN_HEIGHT);
	localparam int         LIN_W    = COORD_W + BOUND_W + 1;

	// ------------------------------------------------------------------
	// Sequencer: step counter plus the control word it selects.
	// Idle step drains the held write and waits for start; scan step loops
	// over all 35 glyph cells, then falls through (wrapping) to idle.
	// ------------------------------------------------------------------
	step_t pc_q;
	ctl_t  ctl;
	logic  take;
	logic  cell_last;
	logic  jump;

	assign ctl       = PROGRAM[pc_q];
	assign busy      = ctl.busy;
	assign take      = start && !ctl.busy;

	always_comb begin
		unique case (ctl.cond)
			JMP_NEVER:      jump = 1'b0;
			JMP_NO_START:   jump = !start;
			JMP_MORE_CELLS: jump = !cell_last;
			default:        jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Clip registers
	// ------------------------------------------------------------------
	logic [7:0] top_row_q;
	logic [7:0] bottom_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_row_q    <= TOP_ROW_RST;
			bottom_row_q <= BOTTOM_ROW_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TOP_ROW:    top_row_q    <= cfg_data;
				REG_BOTTOM_ROW: bottom_row_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath: latched character, cell counters, one held write.
	// A write is held until the next surviving cell shows up, so the
	// one that is still held when the scan ends goes out flagged last.
	// ------------------------------------------------------------------
	glyph_t            glyph_q;
	logic [8:0]        pos_x_q;
	logic [8:0]        pos_y_q;
	logic [15:0]       color_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;
	logic               inside_clip;
	logic               hit;
	logic [ADDR_W-1:0]  lin;

	assign cell_last = (col_q == LAST_COL) && (row_q == LAST_ROW);
	assign x = COORD_W'(pos_x_q) + COORD_W'(col_q);
	assign y = COORD_W'(pos_y_q) + COORD_W'(row_q);

	assign inside_clip = ({1'b0, x} < WIDTH_L)
		&& (y >= COORD_W'(top_row_q))
		&& (y <  COORD_W'(bottom_row_q))
		&& ({1'b0, y} < HEIGHT_L);
	assign hit = ctl.scan && glyph_q[col_q][row_q] && inside_clip;
	assign lin = ADDR_W'(LIN_W'(y) * LIN_W'(WIDTH_L) + LIN_W'(x));

	always_ff @(posedge clk) begin
		if (take) begin
			glyph_q <= font_lookup(command.char_code);
			pos_x_q <= command.pos_x;
			pos_y_q <= command.pos_y;
			color_q <= command.pen_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.scan) begin
			if (row_q == LAST_ROW) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// held write
	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (hit) begin
			pend_q <= 1'b1;
		end else if (ctl.flush) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_addr_q <= lin;
		end
	end

	// ------------------------------------------------------------------
	// Output register: at most one beat per cycle, shown for one cycle only
	// ------------------------------------------------------------------
	logic      emit;
	logic      out_valid_q;
	out_item_t out_q;

	assign emit = pend_q && (hit || ctl.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_address <= pend_addr_q;
			out_q.pixel_color   <= color_q;
			out_q.last_pixel    <= ctl.flush;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy)
		else $error("accepted character did not start a scan");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (col_q <= LAST_COL && row_q <= LAST_ROW))
		else $error("glyph cell counter out of range");

	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(pend_q))
		else $error("write beat without a held write");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_pixel) |-> !pend_q)
		else $error("write still held after the final beat");

endmodule
